// ===== rtl/pkdb_pkg.sv =====
package pkdb_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DT_W   = 24;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned CFG_W  = DT_W;
    // a*dt and v*dt product width (signed 32 x unsigned 24)
    localparam int unsigned PROD_W = DATA_W + DT_W + 1;
    // drifted position, wide enough to hold p + v*dt exactly
    localparam int unsigned POSW_W = 42;

    localparam logic [IDX_W-1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOUNDARY_MODE = 2'd1;

    typedef enum logic [1:0] {
        MODE_PERIODIC = 2'd0,
        MODE_REFLECT  = 2'd1,
        MODE_OPEN     = 2'd2,
        MODE_PASS     = 2'd3
    } t_mode;

    localparam logic signed [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a 33-bit sum to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] x);
        logic signed [DATA_W-1:0] y;
        if (x[DATA_W] != x[DATA_W-1]) begin
            y = x[DATA_W] ? VEL_MIN : VEL_MAX;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

    // negate, most negative value goes to most positive
    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] y;
        if (x == VEL_MIN) begin
            y = VEL_MAX;
        end else begin
            y = -x;
        end
        return y;
    endfunction

endpackage

// ===== rtl/particle_kick_drift_boundary.sv =====
// Leapfrog kick-drift step for particles in the unit box.
// Input: pulse start with one particle word on i_pos_*/i_vel_*/i_acc_* and
// i_final_particle. busy is always low, so a word is taken every cycle start
// is high. Output: o_done strobes for one cycle with the updated particle on
// o_new_*, o_left_box and o_final_out; the receiver must take it then.
// Throughput is one particle per cycle. The depth is set by the two chained
// multipliers; the stages are kick multiply, kick round/add, drift multiply,
// drift round/add, and boundary select feeding the output register.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 time step,
// 1 boundary mode) at the clock edge; other indexes are ignored. Write only
// while no particle is in flight.
// Reset (synchronous, active low) clears both registers and the in-flight
// valid bits; words in flight at reset are dropped. Nothing back-pressures.
module particle_kick_drift_boundary
    import pkdb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [DATA_W-1:0]        i_pos_x,
    input  logic [DATA_W-1:0]        i_pos_y,
    input  logic [DATA_W-1:0]        i_pos_z,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    input  logic signed [DATA_W-1:0] i_acc_x,
    input  logic signed [DATA_W-1:0] i_acc_y,
    input  logic signed [DATA_W-1:0] i_acc_z,
    input  logic                     i_final_particle,
    output logic                     o_done,
    output logic [DATA_W-1:0]        o_new_pos_x,
    output logic [DATA_W-1:0]        o_new_pos_y,
    output logic [DATA_W-1:0]        o_new_pos_z,
    output logic signed [DATA_W-1:0] o_new_vel_x,
    output logic signed [DATA_W-1:0] o_new_vel_y,
    output logic signed [DATA_W-1:0] o_new_vel_z,
    output logic signed [DATA_W-1:0] o_new_acc_x,
    output logic signed [DATA_W-1:0] o_new_acc_y,
    output logic signed [DATA_W-1:0] o_new_acc_z,
    output logic                     o_left_box,
    output logic                     o_final_out
);

    localparam int unsigned DEPTH = 5;

    logic [DT_W-1:0]  r_time_step;
    t_mode            r_mode;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_fin;
    logic             n_accept;

    // per-axis input and output views
    logic [DATA_W-1:0]        in_pos [3];
    logic signed [DATA_W-1:0] in_vel [3];
    logic signed [DATA_W-1:0] in_acc [3];
    logic [DATA_W-1:0]        out_pos [3];
    logic signed [DATA_W-1:0] out_vel [3];
    logic signed [DATA_W-1:0] out_acc [3];
    logic [2:0]               out_left;

    // never back-pressures: one word per cycle
    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;
    assign in_vel[0] = i_vel_x;
    assign in_vel[1] = i_vel_y;
    assign in_vel[2] = i_vel_z;
    assign in_acc[0] = i_acc_x;
    assign in_acc[1] = i_acc_y;
    assign in_acc[2] = i_acc_z;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0;
            r_mode      <= MODE_PERIODIC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_STEP:     r_time_step <= i_cfg_data[DT_W-1:0];
                REG_BOUNDARY_MODE: r_mode      <= t_mode'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    // valid bits and the last-particle marker ride alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], n_accept};
        end
        r_fin <= {r_fin[DEPTH-2:0], i_final_particle};
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            logic [DATA_W-1:0]        k_pos, d_pos;
            logic signed [DATA_W-1:0] k_vo, k_vn, k_acc, d_vo, d_vn, d_acc;
            logic signed [POSW_W-1:0] d_pnew;

            pkdb_kick u_kick (
                .i_clk      (i_clk),
                .i_dt       (r_time_step),
                .i_pos      (in_pos[g]),
                .i_vel      (in_vel[g]),
                .i_acc      (in_acc[g]),
                .o_pos      (k_pos),
                .o_vel_orig (k_vo),
                .o_vel_new  (k_vn),
                .o_acc      (k_acc)
            );

            pkdb_drift u_drift (
                .i_clk      (i_clk),
                .i_dt       (r_time_step),
                .i_pos      (k_pos),
                .i_vel_orig (k_vo),
                .i_vel_new  (k_vn),
                .i_acc      (k_acc),
                .o_pos_new  (d_pnew),
                .o_pos      (d_pos),
                .o_vel_orig (d_vo),
                .o_vel_new  (d_vn),
                .o_acc      (d_acc)
            );

            pkdb_bound u_bound (
                .i_clk      (i_clk),
                .i_mode     (r_mode),
                .i_pos_new  (d_pnew),
                .i_pos      (d_pos),
                .i_vel_orig (d_vo),
                .i_vel_new  (d_vn),
                .i_acc      (d_acc),
                .o_pos      (out_pos[g]),
                .o_vel      (out_vel[g]),
                .o_acc      (out_acc[g]),
                .o_left     (out_left[g])
            );
        end
    endgenerate

    assign o_done      = r_vld[DEPTH-1];
    assign o_final_out = r_fin[DEPTH-1];
    assign o_left_box  = |out_left;
    assign o_new_pos_x = out_pos[0];
    assign o_new_pos_y = out_pos[1];
    assign o_new_pos_z = out_pos[2];
    assign o_new_vel_x = out_vel[0];
    assign o_new_vel_y = out_vel[1];
    assign o_new_vel_z = out_vel[2];
    assign o_new_acc_x = out_acc[0];
    assign o_new_acc_y = out_acc[1];
    assign o_new_acc_z = out_acc[2];

    // every accepted word comes out with an o_done strobe once through the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##5 o_done)
        else $error("accepted word did not emerge after pipeline latency");

    // left-box flag only in open mode
    a_left_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_mode) != MODE_OPEN) |-> !o_left_box)
        else $error("left_box set outside open mode");

    // pass-through mode returns the position untouched
    a_pass_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_mode) == MODE_PASS) |-> (o_new_pos_x == $past(i_pos_x, 5)))
        else $error("pass-through mode altered position");

endmodule

// ===== rtl/pkdb_kick.sv =====
// Half-step velocity kick, two stages: multiply, then round and add.
module pkdb_kick
    import pkdb_pkg::*;
(
    input  logic                     i_clk,
    input  logic [DT_W-1:0]          i_dt,
    input  logic [DATA_W-1:0]        i_pos,
    input  logic signed [DATA_W-1:0] i_vel,
    input  logic signed [DATA_W-1:0] i_acc,
    output logic [DATA_W-1:0]        o_pos,
    output logic signed [DATA_W-1:0] o_vel_orig,
    output logic signed [DATA_W-1:0] o_vel_new,
    output logic signed [DATA_W-1:0] o_acc
);

    localparam logic signed [PROD_W-1:0] KICK_RND = PROD_W'(1) <<< 24;

    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_pos1, r_pos2;
    logic signed [DATA_W-1:0] r_vel1, r_vel2, r_acc1, r_acc2, r_vnew;

    logic signed [PROD_W-1:0] n_sum;
    logic signed [DATA_W-1:0] n_delta;

    always_comb begin
        n_sum   = r_prod + KICK_RND;
        n_delta = n_sum[PROD_W-1:25];   // half the Q8.48 product, rounded (ties go up)
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_acc * $signed({1'b0, i_dt});
        r_pos1 <= i_pos;
        r_vel1 <= i_vel;
        r_acc1 <= i_acc;

        r_vnew <= sat33({r_vel1[DATA_W-1], r_vel1} + {n_delta[DATA_W-1], n_delta});
        r_pos2 <= r_pos1;
        r_vel2 <= r_vel1;
        r_acc2 <= r_acc1;
    end

    assign o_pos      = r_pos2;
    assign o_vel_orig = r_vel2;
    assign o_vel_new  = r_vnew;
    assign o_acc      = r_acc2;

endmodule

// ===== rtl/pkdb_drift.sv =====
// Position drift, two stages: multiply, then round and add (kept wide).
module pkdb_drift
    import pkdb_pkg::*;
(
    input  logic                     i_clk,
    input  logic [DT_W-1:0]          i_dt,
    input  logic [DATA_W-1:0]        i_pos,
    input  logic signed [DATA_W-1:0] i_vel_orig,
    input  logic signed [DATA_W-1:0] i_vel_new,
    input  logic signed [DATA_W-1:0] i_acc,
    output logic signed [POSW_W-1:0] o_pos_new,
    output logic [DATA_W-1:0]        o_pos,
    output logic signed [DATA_W-1:0] o_vel_orig,
    output logic signed [DATA_W-1:0] o_vel_new,
    output logic signed [DATA_W-1:0] o_acc
);

    localparam logic signed [PROD_W-1:0] DRIFT_RND = PROD_W'(1) <<< 15;
    localparam int unsigned DP_W = PROD_W - 16;

    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_pos1, r_pos2;
    logic signed [DATA_W-1:0] r_vo1, r_vo2, r_vn1, r_vn2, r_acc1, r_acc2;
    logic signed [POSW_W-1:0] r_pnew;

    logic signed [PROD_W-1:0] n_sum;
    logic signed [DP_W-1:0]   n_dp;

    always_comb begin
        n_sum = r_prod + DRIFT_RND;
        n_dp  = n_sum[PROD_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_vel_new * $signed({1'b0, i_dt});
        r_pos1 <= i_pos;
        r_vo1  <= i_vel_orig;
        r_vn1  <= i_vel_new;
        r_acc1 <= i_acc;

        r_pnew <= $signed({{(POSW_W-DATA_W){1'b0}}, r_pos1})
                + $signed({{(POSW_W-DP_W){n_dp[DP_W-1]}}, n_dp});
        r_pos2 <= r_pos1;
        r_vo2  <= r_vo1;
        r_vn2  <= r_vn1;
        r_acc2 <= r_acc1;
    end

    assign o_pos_new  = r_pnew;
    assign o_pos      = r_pos2;
    assign o_vel_orig = r_vo2;
    assign o_vel_new  = r_vn2;
    assign o_acc      = r_acc2;

endmodule

// ===== rtl/pkdb_bound.sv =====
// Boundary handling per axis, registered output.
module pkdb_bound
    import pkdb_pkg::*;
(
    input  logic                     i_clk,
    input  t_mode                    i_mode,
    input  logic signed [POSW_W-1:0] i_pos_new,
    input  logic [DATA_W-1:0]        i_pos,
    input  logic signed [DATA_W-1:0] i_vel_orig,
    input  logic signed [DATA_W-1:0] i_vel_new,
    input  logic signed [DATA_W-1:0] i_acc,
    output logic [DATA_W-1:0]        o_pos,
    output logic signed [DATA_W-1:0] o_vel,
    output logic signed [DATA_W-1:0] o_acc,
    output logic                     o_left
);

    localparam logic signed [POSW_W-1:0] TWO_BOX = POSW_W'(1) <<< (DATA_W + 1);

    logic [DATA_W-1:0]        r_pos, n_pos;
    logic signed [DATA_W-1:0] r_vel, n_vel, r_acc, n_acc;
    logic                     r_left, n_left;
    logic                     n_oor;
    logic signed [POSW_W-1:0] n_mir;

    always_comb begin
        n_oor  = i_pos_new[POSW_W-1] || (i_pos_new[POSW_W-2:DATA_W] != '0);
        n_mir  = i_pos_new[POSW_W-1] ? -i_pos_new : (TWO_BOX - i_pos_new);
        n_pos  = i_pos_new[DATA_W-1:0];
        n_vel  = i_vel_new;
        n_acc  = i_acc;
        n_left = 1'b0;
        case (i_mode)
            MODE_PERIODIC: begin
                n_pos = i_pos_new[DATA_W-1:0];
            end
            MODE_REFLECT: begin
                if (n_oor) begin
                    // mirror, then clamp into the box
                    if (n_mir[POSW_W-1]) begin
                        n_pos = '0;
                    end else if (n_mir[POSW_W-2:DATA_W] != '0) begin
                        n_pos = '1;
                    end else begin
                        n_pos = n_mir[DATA_W-1:0];
                    end
                    n_vel = neg_sat(i_vel_new);
                    n_acc = neg_sat(i_acc);
                end
            end
            MODE_OPEN: begin
                n_left = n_oor;
            end
            MODE_PASS: begin
                n_pos = i_pos;
                n_vel = i_vel_orig;
            end
            default: begin
                n_pos = i_pos_new[DATA_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_vel  <= n_vel;
        r_acc  <= n_acc;
        r_left <= n_left;
    end

    assign o_pos  = r_pos;
    assign o_vel  = r_vel;
    assign o_acc  = r_acc;
    assign o_left = r_left;

endmodule

// ===== verif/particle_kick_drift_boundary_tb.sv =====
// Kick-drift-boundary particle unit testbench.
// Particle words go in on start/busy; every accepted word is run through a
// local fixed-point predictor and its result queued. Each o_done strobe is
// compared field by field with the oldest queued result.
module particle_kick_drift_boundary_tb;
    import pkdb_pkg::*;

    // register indexes outside the map; writes to these must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int     PIPE_LAT   = 5;      // accept edge to o_done edge
    localparam int     QUIET_MAX  = 1000;   // cycles with no traffic at all
    localparam int     GAP_PCT    = 5;      // percent chance of an idle gap before a word
    localparam int     PHASES     = 12;
    localparam int     PHASE_WORDS = 150;

    localparam longint BOX_ONE   = 64'sh1_0000_0000;   // 1.0 in Q0.32
    localparam longint Q824_MAX  = 64'sd2147483647;
    localparam longint Q824_MIN  = -64'sd2147483648;
    localparam logic [31:0] ONE_Q824 = 32'h0100_0000;
    localparam logic [CFG_W-1:0] DT_MAX  = 24'hFF_FFFF;
    localparam logic [CFG_W-1:0] DT_HALF = 24'h80_0000;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic             last;
    } t_particle;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic             off_box;
        logic             last;
    } t_moved;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic [DATA_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [DATA_W-1:0] i_vel_x, i_vel_y, i_vel_z;
    logic signed [DATA_W-1:0] i_acc_x, i_acc_y, i_acc_z;
    logic i_final_particle;
    logic o_done;
    logic [DATA_W-1:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [DATA_W-1:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic signed [DATA_W-1:0] o_new_acc_x, o_new_acc_y, o_new_acc_z;
    logic o_left_box;
    logic o_final_out;

    // local copy of the two config registers
    logic [DT_W-1:0] step_dt;
    t_mode           step_mode;

    t_moved moved_q[$];     // predicted particles, oldest first
    int     mismatches;
    int     quiet_cycles;
    bit     gaps_on;

    particle_kick_drift_boundary u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_vel_x          (i_vel_x),
        .i_vel_y          (i_vel_y),
        .i_vel_z          (i_vel_z),
        .i_acc_x          (i_acc_x),
        .i_acc_y          (i_acc_y),
        .i_acc_z          (i_acc_z),
        .i_final_particle (i_final_particle),
        .o_done           (o_done),
        .o_new_pos_x      (o_new_pos_x),
        .o_new_pos_y      (o_new_pos_y),
        .o_new_pos_z      (o_new_pos_z),
        .o_new_vel_x      (o_new_vel_x),
        .o_new_vel_y      (o_new_vel_y),
        .o_new_vel_z      (o_new_vel_z),
        .o_new_acc_x      (o_new_acc_x),
        .o_new_acc_y      (o_new_acc_y),
        .o_new_acc_z      (o_new_acc_z),
        .o_left_box       (o_left_box),
        .o_final_out      (o_final_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_q824(input longint x);
        longint y;
        y = x;
        if (x > Q824_MAX) y = Q824_MAX;
        if (x < Q824_MIN) y = Q824_MIN;
        return y;
    endfunction

    // One leapfrog step: half kick, full drift, then boundary handling; pass mode returns the particle unchanged.
    // >>> on longint is a floor divide, which matches the rounding rule
    // (add half an lsb, floor, ties go up).
    function automatic t_moved advance_particle(input t_particle p,
                                                input logic [DT_W-1:0] dt,
                                                input t_mode mode);
        t_moved m;
        longint pw, vw, aw, dtw;
        m = '0;
        dtw = dt;
        for (int k = 0; k < 3; k++) begin
            pw = p.pos[k];
            vw = longint'($signed(p.vel[k]));
            aw = longint'($signed(p.acc[k]));
            if (mode != MODE_PASS) begin
                vw = clamp_q824(vw + ((aw * dtw + (64'sd1 << 24)) >>> 25));
                pw = pw + ((vw * dtw + (64'sd1 << 15)) >>> 16);
                case (mode)
                    MODE_PERIODIC: begin
                        pw = pw & (BOX_ONE - 1);
                    end
                    MODE_REFLECT: begin
                        if (pw < 0 || pw >= BOX_ONE) begin
                            // mirror about the crossed wall, then clamp for
                            // exact-1.0 landings and multi-box overshoot
                            pw = (pw >= BOX_ONE) ? 2 * BOX_ONE - pw : -pw;
                            if (pw < 0) pw = 0;
                            if (pw > BOX_ONE - 1) pw = BOX_ONE - 1;
                            vw = clamp_q824(-vw);
                            aw = clamp_q824(-aw);
                        end
                    end
                    default: begin
                        if (pw < 0 || pw >= BOX_ONE) m.off_box = 1'b1;
                        pw = pw & (BOX_ONE - 1);
                    end
                endcase
            end
            m.pos[k] = pw[31:0];
            m.vel[k] = vw[31:0];
            m.acc[k] = aw[31:0];
        end
        m.last = p.last;
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_particle uniform_particle(input logic [31:0] pos,
                                                   input logic [31:0] vel,
                                                   input logic [31:0] acc,
                                                   input logic last);
        t_particle p;
        for (int k = 0; k < 3; k++) begin
            p.pos[k] = pos;
            p.vel[k] = vel;
            p.acc[k] = acc;
        end
        p.last = last;
        return p;
    endfunction

    function automatic logic [31:0] rand_pos();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: r = '0;
            1: r = '1;
            2: r = $urandom_range(0, 255);
            3: r = r | 32'hFFFF_FF00;
            default: ;
        endcase
        return r;
    endfunction

    // mostly moderate values so particles move a fraction of a box;
    // full-range and extreme words now and then
    function automatic logic [31:0] rand_q824(input bit wild);
        logic signed [31:0] r;
        r = $urandom;
        if (!wild) begin
            r = r >>> $urandom_range(4, 14);
        end else begin
            case ($urandom_range(0, 5))
                0: r = VEL_MAX;
                1: r = VEL_MIN;
                2: r = '0;
                3: r = '1;
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_particle random_particle(input bit wild);
        t_particle p;
        for (int k = 0; k < 3; k++) begin
            p.pos[k] = rand_pos();
            p.vel[k] = rand_q824(wild);
            p.acc[k] = rand_q824(wild);
        end
        p.last = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // Drive one particle word and hold it until the accepting edge.
    // start stays high on return; the next word or a gap replaces it.
    task automatic send_particle(input t_particle p);
        if (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start            <= 1'b1;
        i_pos_x          <= p.pos[0];
        i_pos_y          <= p.pos[1];
        i_pos_z          <= p.pos[2];
        i_vel_x          <= p.vel[0];
        i_vel_y          <= p.vel[1];
        i_vel_z          <= p.vel[2];
        i_acc_x          <= p.acc[0];
        i_acc_y          <= p.acc[1];
        i_acc_z          <= p.acc[2];
        i_final_particle <= p.last;
        do @(posedge i_clk); while (busy);
        moved_q.push_back(advance_particle(p, step_dt, step_mode));
    endtask

    // Stop sending and wait for the pipe to empty.
    task automatic settle_pipe();
        @(negedge i_clk);
        start <= 1'b0;
        while (moved_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle_pipe();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_TIME_STEP) begin
            step_dt = data[DT_W-1:0];
        end else if (idx == REG_BOUNDARY_MODE) begin
            step_mode = t_mode'(data[1:0]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // dt is 0 out of reset: kick and drift both round to zero
    task automatic test_reset_defaults();
        send_particle(uniform_particle('1, VEL_MIN, VEL_MAX, 1'b1));
        send_particle(uniform_particle('0, '0, '0, 1'b0));
    endtask

    task automatic test_periodic_wrap();
        t_particle p;
        write_reg(REG_TIME_STEP, DT_MAX);
        write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_PERIODIC));
        // wraps past the top
        send_particle(uniform_particle(32'hFFFF_F000, ONE_Q824, '0, 1'b0));
        // wraps below zero
        send_particle(uniform_particle(32'h0000_0100, -ONE_Q824, '0, 1'b0));
        // kick saturates high and low
        send_particle(uniform_particle(32'h8000_0000, VEL_MAX, VEL_MAX, 1'b0));
        send_particle(uniform_particle(32'h8000_0000, VEL_MIN, VEL_MIN, 1'b1));
        // mixed axes, small accelerations for the rounding path
        p = uniform_particle(32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        p.acc[1] = 32'h0000_0002;
        p.vel[2] = 32'hFFFF_FFFF;
        send_particle(p);
    endtask

    task automatic test_reflect_walls();
        t_particle p;
        write_reg(REG_TIME_STEP, DT_HALF);
        write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_REFLECT));
        // x lands exactly on 1.0, y dips below 0, z stays inside
        p = uniform_particle(32'h4000_0000, '0, '0, 1'b0);
        p.pos[0] = 32'h8000_0000;
        p.vel[0] = ONE_Q824;
        p.pos[1] = 32'h0000_1000;
        p.vel[1] = -ONE_Q824;
        send_particle(p);
        // overshoot by many boxes both ways; z negates the most negative acc
        p = uniform_particle('0, '0, '0, 1'b0);
        p.vel[0] = VEL_MAX;
        p.vel[1] = VEL_MIN;
        p.vel[2] = -ONE_Q824;
        p.acc[2] = VEL_MIN;
        send_particle(p);
        // resting at zero is not a crossing
        send_particle(uniform_particle('0, '0, '0, 1'b0));
        send_particle(uniform_particle('1, '0, 32'h0000_8000, 1'b1));
    endtask

    task automatic test_open_box();
        t_particle p;
        write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_OPEN));
        p = uniform_particle(32'h4000_0000, '0, '0, 1'b0);
        p.pos[0] = 32'hF000_0000;
        p.vel[0] = ONE_Q824;
        send_particle(p);
        p = uniform_particle(32'h4000_0000, '0, '0, 1'b0);
        p.pos[2] = 32'h0000_0010;
        p.vel[2] = -ONE_Q824;
        send_particle(p);
        send_particle(uniform_particle(32'h4000_0000, 32'h0010_0000, '0, 1'b0));
        // exactly 1.0 is outside
        p = uniform_particle(32'h4000_0000, '0, '0, 1'b1);
        p.pos[1] = 32'h8000_0000;
        p.vel[1] = ONE_Q824;
        send_particle(p);
    endtask

    task automatic test_pass_mode();
        write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_PASS));
        send_particle(uniform_particle('1, VEL_MAX, VEL_MIN, 1'b1));
        send_particle(uniform_particle('0, VEL_MIN, VEL_MAX, 1'b0));
    endtask

    // writes to unmapped indexes must leave both registers alone
    task automatic test_ignored_index();
        write_reg(REG_TIME_STEP, 24'h00_0400);
        write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_PERIODIC));
        write_reg(REG_SPARE_2, DT_MAX);
        write_reg(REG_SPARE_3, 24'h00_0003);
        send_particle(uniform_particle(32'hFFFF_FFF0, VEL_MAX, VEL_MAX, 1'b0));
        send_particle(uniform_particle(32'h0000_0008, VEL_MIN, VEL_MIN, 1'b1));
    endtask

    // Phases of random particles, each under its own dt and mode. Each
    // phase boundary drains the pipe, which also holds the sender off
    // until every result is back. One phase runs with no gaps at all.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] dt;
        logic [CFG_W-1:0] mode_word;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: dt = DT_MAX;
                1: dt = '0;
                2: dt = 24'h00_0001;
                3: dt = DT_HALF;
                default: dt = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom)
                                                           : CFG_W'($urandom_range(0, 65535));
            endcase
            // upper bits of the mode word are junk the register must drop
            mode_word = CFG_W'($urandom);
            mode_word[1:0] = 2'(ph % 4);
            write_reg(REG_TIME_STEP, dt);
            write_reg(REG_BOUNDARY_MODE, mode_word);
            gaps_on = (ph != 5);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_particle(random_particle($urandom_range(0, 99) < 15));
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_word(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_moved want;
        if (i_rst_n && o_done) begin
            if (moved_q.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result word: expected none, got pos_x %h",
                         $time, o_new_pos_x);
            end else begin
                want = moved_q.pop_front();
                compare_word("pos_x", want.pos[0], o_new_pos_x);
                compare_word("pos_y", want.pos[1], o_new_pos_y);
                compare_word("pos_z", want.pos[2], o_new_pos_z);
                compare_word("vel_x", want.vel[0], o_new_vel_x);
                compare_word("vel_y", want.vel[1], o_new_vel_y);
                compare_word("vel_z", want.vel[2], o_new_vel_z);
                compare_word("acc_x", want.acc[0], o_new_acc_x);
                compare_word("acc_y", want.acc[1], o_new_acc_y);
                compare_word("acc_z", want.acc[2], o_new_acc_z);
                compare_word("left_box", 32'(want.off_box), 32'(o_left_box));
                compare_word("final_out", 32'(want.last), 32'(o_final_out));
            end
        end
    end

    // Watchdog: any accepted word, result or register write resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_pos_x          = '0;
        i_pos_y          = '0;
        i_pos_z          = '0;
        i_vel_x          = '0;
        i_vel_y          = '0;
        i_vel_z          = '0;
        i_acc_x          = '0;
        i_acc_y          = '0;
        i_acc_z          = '0;
        i_final_particle = 1'b0;
        step_dt          = '0;
        step_mode        = MODE_PERIODIC;
        mismatches       = 0;
        quiet_cycles     = 0;
        gaps_on          = 1'b1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_periodic_wrap();
        test_reflect_walls();
        test_open_box();
        test_pass_mode();
        test_ignored_index();
        test_random_traffic();

        settle_pipe();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (mismatches == 0 && moved_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
